// ===== rtl/core/median_ema_distance_filter_top_assert.svh =====
// Assertion macros shared by the distance filter RTL
`ifndef MEDIAN_EMA_DISTANCE_FILTER_TOP_ASSERT_SVH
`define MEDIAN_EMA_DISTANCE_FILTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/medf_pkg.sv =====
// Types and constants of the median and moving-average distance filter
`timescale 1ns / 1ps

package medf_pkg;

  // field widths
  localparam int DIST_W   = 16;
  localparam int STATUS_W = 8;
  localparam int GAIN_W   = 16;
  localparam int AVG_W    = 24;
  localparam int FRAC_W   = 8;
  localparam int PROD_W   = GAIN_W + AVG_W;

  // q1.15 gain of one and the half-lsb used for rounding the blend
  localparam logic [GAIN_W-1:0] GAIN_ONE      = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd16384;
  localparam logic [PROD_W-1:0] BLEND_ROUND   = 40'd16384;
  localparam logic [AVG_W:0]    OUT_ROUND     = 25'd128;
  localparam logic [AVG_W-1:0]  AVG_MAX       = 24'hFFFFFF;
  localparam logic [AVG_W-1:0]  AVG_LIMIT     = 24'hFFFF00;
  localparam logic [DIST_W-1:0] DIST_MAX      = 16'hFFFF;

  // sequencer states
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_RD_I  = 8'b0000_0010,
    ST_CAND  = 8'b0000_0100,
    ST_SWEEP = 8'b0000_1000,
    ST_CHECK = 8'b0001_0000,
    ST_MUL_A = 8'b0010_0000,
    ST_MUL_B = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

endpackage

// ===== rtl/core/medf_ram.sv =====
// Generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps

module medf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 5
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/median_ema_distance_filter_top.sv =====
// Distance filter: ring window, upper median search, exponential average
//
// Usage:
//   Input channel (in_valid/in_ready) carries distance_mm, range_status and
//   read_error. A request with read_error clear and range_status zero is a good
//   sample; it goes into a ring window of WINDOW_SIZE entries, the upper median
//   of the filled entries is found, and that median seeds or updates an
//   exponential average kept in q16.8. Output channel (out_valid/out_ready)
//   returns one result per input request: filtered_mm and sample_accepted.
//   A bad sample returns the previous filtered_mm with sample_accepted low.
//   cfg_write/cfg_data set the q1.15 gain of the new median (values above one
//   act as one); write it only while the block is idle.
// Sequence (n = filled entries after the write, 1..WINDOW_SIZE):
//   bad sample: goes straight from accept to the done state and its result.
//   good sample: candidates are tried in entry order; for each, the median
//   search reads the n window RAM entries one entry per cycle and counts
//   those below and at or below it, and it stops at the candidate where the
//   median sits. The seeding sample sets the average; the blend of later
//   ones uses one 16x24 multiplier twice. in_ready is high only in idle.
// Reset clears window fill, average, last output and gain (0.5). If the
// receiver stalls, the finished result holds; the next request is still taken
// and worked, and its result then waits until the output register is free.
`timescale 1ns / 1ps

`include "median_ema_distance_filter_top_assert.svh"

module median_ema_distance_filter_top #(
  parameter int WINDOW_SIZE = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [medf_pkg::DIST_W-1:0]    distance_mm,
  input  logic [medf_pkg::STATUS_W-1:0]  range_status,
  input  logic                           read_error,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [medf_pkg::DIST_W-1:0]    filtered_mm,
  output logic                           sample_accepted,
  // gain register
  input  logic                           cfg_write,
  input  logic [medf_pkg::GAIN_W-1:0]    cfg_data
);

  localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW = $clog2(WINDOW_SIZE + 1);
  localparam logic [CW-1:0] FILL_FULL = CW'(WINDOW_SIZE);
  localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW_SIZE - 1);

  medf_pkg::state_t state;

  // control and architectural state
  logic [CW-1:0]                fill_count;
  logic [AW-1:0]                write_slot;
  logic [medf_pkg::AVG_W-1:0]   average_q16_8;
  logic                         average_seeded;
  logic [medf_pkg::DIST_W-1:0]  last_output;
  logic [medf_pkg::GAIN_W-1:0]  smoothing_gain;

  // working registers of the search and blend
  logic                         good_sample;
  logic [AW-1:0]                cand_idx;
  logic [medf_pkg::DIST_W-1:0]  cand;
  logic [CW-1:0]                sweep_idx;
  logic                         pend;
  logic [CW-1:0]                below;
  logic [CW-1:0]                at_or_below;
  logic [medf_pkg::PROD_W-1:0]  acc;

  // ram ports
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [medf_pkg::DIST_W-1:0]  ram_rdata;

  logic                         in_fire;
  logic                         in_good;
  logic [CW-1:0]                rank;
  logic                         hit;
  logic                         out_free;

  logic [medf_pkg::GAIN_W-1:0]  gain_eff;
  logic [medf_pkg::GAIN_W-1:0]  gain_inv;
  logic [medf_pkg::GAIN_W-1:0]  mul_a;
  logic [medf_pkg::AVG_W-1:0]   mul_b;
  logic [medf_pkg::PROD_W-1:0]  prod;
  logic [medf_pkg::PROD_W-1:0]  blend_sum;
  logic [medf_pkg::AVG_W:0]     blend_q;
  logic [medf_pkg::AVG_W-1:0]   blend_avg;
  logic [medf_pkg::AVG_W:0]     round_sum;
  logic [medf_pkg::DIST_W:0]    round_q;
  logic [medf_pkg::DIST_W-1:0]  rounded;

  // handshake and sample check
  assign in_ready = (state == medf_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_good  = !read_error && (range_status == '0);
  assign out_free = !out_valid || out_ready;

  // window write goes to the next free entry, then to the ring slot
  assign ram_we    = in_fire && in_good;
  assign ram_waddr = (fill_count < FILL_FULL) ? fill_count[AW-1:0] : write_slot;
  assign ram_raddr = (state == medf_pkg::ST_SWEEP) ? sweep_idx[AW-1:0] : cand_idx;

  medf_ram #(
    .WIDTH (medf_pkg::DIST_W),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (distance_mm),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // rank test of the current candidate
  assign rank = fill_count >> 1;
  assign hit  = (below <= rank) && (rank < at_or_below);

  // shared multiplier: gain times median, then one-minus-gain times average
  assign gain_eff  = (smoothing_gain > medf_pkg::GAIN_ONE) ? medf_pkg::GAIN_ONE
                                                           : smoothing_gain;
  assign gain_inv  = medf_pkg::GAIN_ONE - gain_eff;
  assign mul_a     = (state == medf_pkg::ST_MUL_A) ? gain_eff : gain_inv;
  assign mul_b     = (state == medf_pkg::ST_MUL_A) ? {cand, {medf_pkg::FRAC_W{1'b0}}}
                                                   : average_q16_8;
  assign prod      = medf_pkg::PROD_W'(mul_a) * medf_pkg::PROD_W'(mul_b);
  assign blend_sum = acc + prod + medf_pkg::BLEND_ROUND;
  assign blend_q   = blend_sum[medf_pkg::PROD_W-1:15];
  assign blend_avg = blend_q[medf_pkg::AVG_W] ? medf_pkg::AVG_MAX
                                              : blend_q[medf_pkg::AVG_W-1:0];

  // output rounding with saturation
  assign round_sum = {1'b0, average_q16_8} + medf_pkg::OUT_ROUND;
  assign round_q   = round_sum[medf_pkg::AVG_W:medf_pkg::FRAC_W];
  assign rounded   = round_q[medf_pkg::DIST_W] ? medf_pkg::DIST_MAX
                                               : round_q[medf_pkg::DIST_W-1:0];

  // gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_gain <= medf_pkg::GAIN_RESET;
    end else if (cfg_write) begin
      smoothing_gain <= cfg_data;
    end
  end

  // sequencer, control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= medf_pkg::ST_IDLE;
      fill_count     <= '0;
      write_slot     <= '0;
      average_q16_8  <= '0;
      average_seeded <= 1'b0;
      last_output    <= '0;
      out_valid      <= 1'b0;
    end else begin
      // the done state refills the output register itself
      if (out_valid && out_ready && (state != medf_pkg::ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        medf_pkg::ST_IDLE: begin
          if (in_fire) begin
            good_sample <= in_good;
            cand_idx    <= '0;
            if (in_good) begin
              if (fill_count < FILL_FULL) begin
                fill_count <= fill_count + 1'b1;
              end
              write_slot <= (write_slot == SLOT_LAST) ? '0 : write_slot + 1'b1;
              state      <= medf_pkg::ST_RD_I;
            end else begin
              state <= medf_pkg::ST_DONE;
            end
          end
        end
        medf_pkg::ST_RD_I: begin
          state <= medf_pkg::ST_CAND;
        end
        medf_pkg::ST_CAND: begin
          cand        <= ram_rdata;
          sweep_idx   <= '0;
          pend        <= 1'b0;
          below       <= '0;
          at_or_below <= '0;
          state       <= medf_pkg::ST_SWEEP;
        end
        medf_pkg::ST_SWEEP: begin
          // compare the entry read last cycle, issue the next read
          if (pend) begin
            if (ram_rdata < cand) begin
              below <= below + 1'b1;
            end
            if (ram_rdata <= cand) begin
              at_or_below <= at_or_below + 1'b1;
            end
          end
          if (sweep_idx < fill_count) begin
            sweep_idx <= sweep_idx + 1'b1;
            pend      <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= medf_pkg::ST_CHECK;
            end
          end
        end
        medf_pkg::ST_CHECK: begin
          if (hit) begin
            if (average_seeded) begin
              state <= medf_pkg::ST_MUL_A;
            end else begin
              average_q16_8  <= {cand, {medf_pkg::FRAC_W{1'b0}}};
              average_seeded <= 1'b1;
              state          <= medf_pkg::ST_DONE;
            end
          end else begin
            cand_idx <= cand_idx + 1'b1;
            state    <= medf_pkg::ST_RD_I;
          end
        end
        medf_pkg::ST_MUL_A: begin
          acc   <= prod;
          state <= medf_pkg::ST_MUL_B;
        end
        medf_pkg::ST_MUL_B: begin
          average_q16_8 <= blend_avg;
          state         <= medf_pkg::ST_DONE;
        end
        medf_pkg::ST_DONE: begin
          // hand the result over once the output register is free
          if (out_free) begin
            out_valid       <= 1'b1;
            sample_accepted <= good_sample;
            if (good_sample) begin
              filtered_mm <= rounded;
              last_output <= rounded;
            end else begin
              filtered_mm <= last_output;
            end
            state <= medf_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= medf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // window fill never passes the window size
  `ASSERT_IMPLIES(a_fill_bound, clk, rst, 1'b1, fill_count <= FILL_FULL)
  // the average stays inside the q16.8 range of a 16-bit median
  `ASSERT_IMPLIES(a_avg_range, clk, rst, average_seeded, average_q16_8 <= medf_pkg::AVG_LIMIT)
  // a rejected sample repeats the last filtered value
  `ASSERT_IMPLIES(a_reject_hold, clk, rst, out_valid && !sample_accepted, filtered_mm == last_output)
  // a missed candidate always leaves another filled entry to try
  `ASSERT_IMPLIES(a_search_bound, clk, rst, (state == medf_pkg::ST_CHECK) && !hit, CW'(cand_idx) + 1'b1 < fill_count)
  // the blend only runs on a seeded average
  `ASSERT_NEXT(a_blend_seeded, clk, rst, state == medf_pkg::ST_CHECK && hit && !average_seeded, state == medf_pkg::ST_DONE && average_seeded)

endmodule

// ===== tb/sv/tb_median_ema_distance_filter_top.sv =====
// Testbench for the median then exponential average distance filter
`timescale 1ns / 1ps

module tb_median_ema_distance_filter_top;

  localparam int WIN_DEPTH   = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 60;
  localparam int SHOWN_ERRORS = 10;

  // widths and constants of the block
  localparam int DIST_W   = medf_pkg::DIST_W;
  localparam int STATUS_W = medf_pkg::STATUS_W;
  localparam int GAIN_W   = medf_pkg::GAIN_W;
  localparam int AVG_W    = medf_pkg::AVG_W;
  localparam int FRAC_W   = medf_pkg::FRAC_W;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = medf_pkg::GAIN_ONE;
  localparam logic [GAIN_W-1:0] GAIN_RESET = medf_pkg::GAIN_RESET;
  localparam logic [AVG_W:0]    OUT_ROUND  = medf_pkg::OUT_ROUND;
  localparam logic [AVG_W-1:0]  AVG_MAX    = medf_pkg::AVG_MAX;
  localparam logic [DIST_W-1:0] DIST_MAX   = medf_pkg::DIST_MAX;

  typedef struct packed {
    logic [DIST_W-1:0] mm;
    logic              accepted;
  } filter_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [DIST_W-1:0]   distance_mm = '0;
  logic [STATUS_W-1:0] range_status = '0;
  logic                read_error = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DIST_W-1:0]   filtered_mm;
  logic                sample_accepted;
  logic                cfg_write = 1'b0;
  logic [GAIN_W-1:0]   cfg_data = '0;

  // filter state as the block should hold it
  logic [DIST_W-1:0]   win_store [WIN_DEPTH];
  int unsigned         win_fill = 0;
  int unsigned         win_slot = 0;
  logic [AVG_W-1:0]    avg_q16_8 = '0;
  logic                avg_seeded = 1'b0;
  logic [DIST_W-1:0]   held_mm = '0;
  logic [GAIN_W-1:0]   gain_reg = GAIN_RESET;

  filter_result_t      expected_results [$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;

  // sender and receiver pacing
  bit                  gap_enable = 1'b1;
  bit                  stall_enable = 1'b1;
  int unsigned         burst_left = 0;
  bit                  ready_phase = 1'b1;
  int unsigned         phase_left = 0;

  median_ema_distance_filter_top #(
    .WINDOW_SIZE(WIN_DEPTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .distance_mm    (distance_mm),
    .range_status   (range_status),
    .read_error     (read_error),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_mm    (filtered_mm),
    .sample_accepted(sample_accepted),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_median_ema_distance_filter_top: errors");
      $finish;
    end
  end

  // upper median: element of rank fill/2 among the filled entries
  function automatic logic [DIST_W-1:0] window_upper_median();
    logic [DIST_W-1:0] sorted [WIN_DEPTH];
    logic [DIST_W-1:0] key;
    int j;
    for (int i = 0; i < win_fill; i++) sorted[i] = win_store[i];
    for (int i = 1; i < win_fill; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j+1] = sorted[j];
        j--;
      end
      sorted[j+1] = key;
    end
    return sorted[win_fill / 2];
  endfunction

  // advance the filter state by one request and return the result it gives
  function automatic filter_result_t filter_step(logic [DIST_W-1:0] sample_mm,
                                                 logic [STATUS_W-1:0] status,
                                                 logic err);
    filter_result_t res;
    logic [63:0] med64;
    logic [63:0] g64;
    logic [63:0] blend;
    logic [AVG_W:0] rounded;
    if (err || status != '0) begin
      res.mm = held_mm;
      res.accepted = 1'b0;
      return res;
    end
    // ring window: fill first, then overwrite the oldest
    if (win_fill < WIN_DEPTH) begin
      win_store[win_fill] = sample_mm;
      win_fill++;
    end else begin
      win_store[win_slot] = sample_mm;
    end
    win_slot = (win_slot + 1) % WIN_DEPTH;
    med64 = {48'd0, window_upper_median()};
    g64 = (gain_reg > GAIN_ONE) ? {48'd0, GAIN_ONE} : {48'd0, gain_reg};
    if (!avg_seeded) begin
      blend = med64 << FRAC_W;
      avg_seeded = 1'b1;
    end else begin
      blend = (g64 * (med64 << FRAC_W) + ({48'd0, GAIN_ONE} - g64) * {40'd0, avg_q16_8}
               + 64'd16384) >> 15;
    end
    if (blend > {40'd0, AVG_MAX}) blend = {40'd0, AVG_MAX};
    avg_q16_8 = blend[AVG_W-1:0];
    rounded = ({1'b0, avg_q16_8} + OUT_ROUND) >> FRAC_W;
    held_mm = (rounded > {9'd0, DIST_MAX}) ? DIST_MAX : rounded[DIST_W-1:0];
    res.mm = held_mm;
    res.accepted = 1'b1;
    return res;
  endfunction

  function automatic void note_failure(string what, logic [31:0] want_v, logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS)
      $display("mismatch %s: expected %0d, got %0d", what, want_v, got_v);
  endfunction

  // scoreboard: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    filter_result_t want;
    if (rst) begin
      win_fill = 0;
      win_slot = 0;
      avg_q16_8 = '0;
      avg_seeded = 1'b0;
      held_mm = '0;
      gain_reg = GAIN_RESET;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(filter_step(distance_mm, range_status, read_error));
      if (cfg_write) gain_reg = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure("result with nothing pending", 0, 32'(filtered_mm));
        end else begin
          want = expected_results.pop_front();
          if (filtered_mm !== want.mm)
            note_failure("filtered_mm", 32'(want.mm), 32'(filtered_mm));
          if (sample_accepted !== want.accepted)
            note_failure("sample_accepted", 32'(want.accepted), 32'(sample_accepted));
        end
      end
    end
  end

  // receiver: ready runs and stalls of random length
  always @(negedge clk) begin
    if (phase_left == 0) begin
      ready_phase = !ready_phase;
      phase_left = ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 6);
    end
    phase_left--;
    out_ready = ready_phase || !stall_enable;
  end

  // send one request, in bursts with random gaps between them
  task automatic send_sample(logic [DIST_W-1:0] sample_mm, logic [STATUS_W-1:0] status,
                             logic err);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_enable) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    distance_mm = sample_mm;
    range_status = status;
    read_error = err;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // stop sending and wait until every pending result has come back
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // gain register write, only with the block idle
  task automatic write_gain(logic [GAIN_W-1:0] gain);
    wait_results_drained();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = gain;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // rejected sample straight after reset, then seeding and a blend at the reset gain
  task automatic test_after_reset();
    send_sample(16'd500, 8'd0, 1'b1);
    send_sample(16'd1000, 8'd0, 1'b0);
    send_sample(16'd3000, 8'd0, 1'b0);
  endtask

  // status and read error checks, each alone and together
  task automatic test_status_checks();
    send_sample(16'd7000, 8'd255, 1'b0);
    send_sample(16'd7000, 8'd1, 1'b0);
    send_sample(16'd7000, 8'd128, 1'b0);
    send_sample(16'd7000, 8'd0, 1'b1);
    send_sample(16'd7000, 8'd255, 1'b1);
    send_sample(16'd0, 8'd0, 1'b0);
  endtask

  // window fill to full, wrap over the oldest, duplicates and field extremes
  task automatic test_window_wrap();
    send_sample(DIST_MAX, 8'd0, 1'b0);
    send_sample(DIST_MAX, 8'd0, 1'b0);
    send_sample(16'd0, 8'd0, 1'b0);
    send_sample(16'd12345, 8'd0, 1'b0);
    send_sample(DIST_MAX, 8'd0, 1'b0);
    send_sample(16'd0, 8'd0, 1'b0);
    send_sample(16'd0, 8'd0, 1'b0);
    send_sample(16'd0, 8'd0, 1'b0);
  endtask

  // gain at zero, one, above one and at the top of the register
  task automatic test_gain_extremes();
    write_gain(16'd0);
    send_sample(DIST_MAX, 8'd0, 1'b0);
    send_sample(DIST_MAX, 8'd0, 1'b0);
    write_gain(GAIN_ONE);
    send_sample(DIST_MAX, 8'd0, 1'b0);
    send_sample(DIST_MAX, 8'd0, 1'b0);
    write_gain(16'hFFFF);
    send_sample(16'd40, 8'd0, 1'b0);
    send_sample(16'd40, 8'd0, 1'b0);
    write_gain(16'd32769);
    send_sample(16'd60000, 8'd0, 1'b0);
    write_gain(16'd1);
    send_sample(16'd3, 8'd0, 1'b0);
  endtask

  // random phases: mostly good samples around a drifting level, some rejects
  task automatic test_random();
    logic [GAIN_W-1:0]   gain;
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   sample_mm;
    logic                err;
    int                  level;
    int                  pick;
    for (int phase = 0; phase < 6; phase++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) gain = GAIN_W'($urandom_range(0, 32768));
      else if (pick == 7) gain = GAIN_W'($urandom_range(32769, 65535));
      else if (pick == 8) gain = GAIN_W'($urandom_range(0, 64));
      else gain = GAIN_W'($urandom_range(32700, 32768));
      write_gain(gain);
      gap_enable = (phase != 2);
      stall_enable = (phase != 2);
      level = $urandom_range(0, 65535);
      for (int n = 0; n < 200; n++) begin
        // sender holds off once per phase until everything is back
        if (n == 100) wait_results_drained();
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          level = level + $urandom_range(0, 512) - 256;
          if (level < 0) level = 0;
          if (level > 65535) level = 65535;
          sample_mm = level[DIST_W-1:0] ^ DIST_W'($urandom_range(0, 63));
        end else if (pick < 8) begin
          sample_mm = DIST_W'($urandom_range(0, 65535));
        end else if (pick == 8) begin
          sample_mm = 16'd0;
        end else begin
          sample_mm = DIST_MAX;
        end
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          status = '0;
          err = 1'b0;
        end else if (pick < 85) begin
          status = STATUS_W'($urandom_range(1, 255));
          err = 1'b0;
        end else if (pick < 93) begin
          status = '0;
          err = 1'b1;
        end else begin
          status = STATUS_W'($urandom_range(1, 255));
          err = 1'b1;
        end
        send_sample(sample_mm, status, err);
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_after_reset();
    test_status_checks();
    test_window_wrap();
    test_gain_extremes();
    test_random();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure("results never returned", expected_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("tb_median_ema_distance_filter_top: clean");
    end else begin
      $display("tb_median_ema_distance_filter_top: errors");
    end
    $finish;
  end

endmodule

// ===== median_ema_distance_filter_top.f =====
+incdir+rtl/core
rtl/core/medf_pkg.sv
rtl/core/medf_ram.sv
rtl/core/median_ema_distance_filter_top.sv
tb/sv/tb_median_ema_distance_filter_top.sv
